### sv/fqir_pkg.sv
package fqir_pkg;

    localparam int DEPTH          = 16;
    localparam int ITEM_BITS      = 32;
    localparam int ADDR_BITS      = $clog2(DEPTH);
    localparam int COUNT_BITS     = $clog2(DEPTH + 1);
    localparam int OP_BITS        = 3;
    localparam int INDEX_BITS     = 4;
    localparam int DATA_BITS      = 32;
    localparam int COUNT_OUT_BITS = 5;

    typedef logic [ADDR_BITS-1:0]  addr_t;
    typedef logic [COUNT_BITS-1:0] count_t;
    typedef logic [ITEM_BITS-1:0]  item_t;

    typedef enum logic [OP_BITS-1:0] {
        OP_APPEND = 3'd0,
        OP_TAKE   = 3'd1,
        OP_READ   = 3'd2,
        OP_REMOVE = 3'd3,
        OP_CLEAR  = 3'd4
    } op_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ_WAIT,
        ST_SHIFT
    } seq_state_t;

    typedef struct packed {
        logic                      status;
        logic [DATA_BITS-1:0]      read_data;
        logic [COUNT_OUT_BITS-1:0] item_count;
    } result_t;

    function automatic addr_t slot_add(addr_t base, addr_t offset);
        logic [ADDR_BITS:0] sum;
        sum = {1'b0, base} + {1'b0, offset};
        if (sum >= (ADDR_BITS + 1)'(DEPTH))
        begin
            sum = sum - (ADDR_BITS + 1)'(DEPTH);
        end
        return sum[ADDR_BITS-1:0];
    endfunction

    function automatic addr_t slot_inc(addr_t a);
        addr_t r;
        if (a == ADDR_BITS'(DEPTH - 1))
        begin
            r = '0;
        end
        else
        begin
            r = a + 1'b1;
        end
        return r;
    endfunction

endpackage

### sv/fqir_in_if.sv
interface fqir_in_if import fqir_pkg::*; ();

    logic                  valid;
    logic                  ready;
    logic [OP_BITS-1:0]    operation;
    logic [INDEX_BITS-1:0] item_index;
    logic [DATA_BITS-1:0]  write_data;

    modport source (output valid, output operation, output item_index, output write_data,
                    input ready);
    modport sink   (input valid, input operation, input item_index, input write_data,
                    output ready);

endinterface

### sv/fqir_out_if.sv
interface fqir_out_if import fqir_pkg::*; ();

    logic                      valid;
    logic                      ready;
    logic                      status;
    logic [DATA_BITS-1:0]      read_data;
    logic [COUNT_OUT_BITS-1:0] item_count;

    modport source (output valid, output status, output read_data, output item_count,
                    input ready);
    modport sink   (input valid, input status, input read_data, input item_count,
                     output ready);

endinterface

### sv/fifo_queue_indexed_remove.sv
// Append, clear, remove and any error load the transaction into the output register on
// accept; take and read load it from the registered RAM read data in READ_WAIT.
// Throughput: one command per cycle while the sequencer is idle and the output slot is
// free; take/read occupy READ_WAIT; remove at index i > 0 but not the last entry holds
// the sequencer in ST_SHIFT, one memory move per cycle over the single write port.
// Reset clears count, head and output valid; the memory is not cleared (no clearing pass).
module fifo_queue_indexed_remove import fqir_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    fqir_in_if.sink    cmd,
    fqir_out_if.source rsp
);

    logic    out_free;
    logic    res_load;
    result_t res;
    logic    mem_wr_en;
    addr_t   mem_wr_addr;
    item_t   mem_wr_data;
    logic    mem_rd_en;
    addr_t   mem_rd_addr;
    item_t   mem_rd_data;

    fqir_seq u_seq (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .out_free    (out_free),
        .res_load    (res_load),
        .res         (res),
        .mem_wr_en   (mem_wr_en),
        .mem_wr_addr (mem_wr_addr),
        .mem_wr_data (mem_wr_data),
        .mem_rd_en   (mem_rd_en),
        .mem_rd_addr (mem_rd_addr),
        .mem_rd_data (mem_rd_data)
    );

    fqir_ram #(
        .WORDS (DEPTH),
        .WIDTH (ITEM_BITS),
        .AW    (ADDR_BITS)
    ) u_ram (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    fqir_out_reg u_out (
        .clk   (clk),
        .rst_n (rst_n),
        .load  (res_load),
        .res   (res),
        .free  (out_free),
        .rsp   (rsp)
    );

endmodule

### sv/fqir_ram.sv
module fqir_ram #(
    parameter int WORDS = 16,
    parameter int WIDTH = 32,
    parameter int AW    = $clog2(WORDS)
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [WORDS];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### sv/fqir_out_reg.sv
module fqir_out_reg import fqir_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        load,
    input  result_t     res,
    output logic        free,
    fqir_out_if.source  rsp
);

    logic    valid_reg;
    logic    valid_next;
    result_t data_reg;

    assign free = !valid_reg || rsp.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= res;
        end
    end

    assign rsp.valid      = valid_reg;
    assign rsp.status     = data_reg.status;
    assign rsp.read_data  = data_reg.read_data;
    assign rsp.item_count = data_reg.item_count;

endmodule

### sv/fqir_seq.sv
module fqir_seq import fqir_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    fqir_in_if.sink    cmd,
    input  logic       out_free,
    output logic       res_load,
    output result_t    res,
    output logic       mem_wr_en,
    output addr_t      mem_wr_addr,
    output item_t      mem_wr_data,
    output logic       mem_rd_en,
    output addr_t      mem_rd_addr,
    input  item_t      mem_rd_data
);

    seq_state_t state_reg, state_next;
    addr_t      head_reg, head_next;
    count_t     count_reg, count_next;
    addr_t      rd_ptr_reg, rd_ptr_next;
    addr_t      wr_ptr_reg, wr_ptr_next;
    count_t     left_reg, left_next;

    logic   accept;
    logic   idx_ok;
    addr_t  idx_addr;
    count_t idx_count;
    addr_t  shift_rd;

    always_comb
    begin
        accept    = cmd.valid && cmd.ready;
        idx_ok    = ({{COUNT_BITS{1'b0}}, cmd.item_index} < {{INDEX_BITS{1'b0}}, count_reg});
        idx_addr  = ADDR_BITS'(cmd.item_index);
        idx_count = COUNT_BITS'(cmd.item_index);
        shift_rd  = slot_inc(rd_ptr_reg);
    end

    assign cmd.ready = (state_reg == ST_IDLE) && out_free;

    always_comb
    begin
        state_next     = state_reg;
        head_next      = head_reg;
        count_next     = count_reg;
        rd_ptr_next    = rd_ptr_reg;
        wr_ptr_next    = wr_ptr_reg;
        left_next      = left_reg;
        mem_wr_en      = 1'b0;
        mem_wr_addr    = wr_ptr_reg;
        mem_wr_data    = cmd.write_data[ITEM_BITS-1:0];
        mem_rd_en      = 1'b0;
        mem_rd_addr    = head_reg;
        res_load       = 1'b0;
        res.status     = 1'b1;
        res.read_data  = '0;
        res.item_count = COUNT_OUT_BITS'(count_reg);

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    res_load = 1'b1;
                    unique case (op_t'(cmd.operation))
                        OP_APPEND:
                        begin
                            if (count_reg < COUNT_BITS'(DEPTH))
                            begin
                                mem_wr_en      = 1'b1;
                                mem_wr_addr    = slot_add(head_reg, ADDR_BITS'(count_reg));
                                count_next     = count_reg + 1'b1;
                                res.status     = 1'b0;
                                res.item_count = COUNT_OUT_BITS'(count_next);
                            end
                        end
                        OP_TAKE:
                        begin
                            if (count_reg != '0)
                            begin
                                res_load    = 1'b0;
                                mem_rd_en   = 1'b1;
                                mem_rd_addr = head_reg;
                                head_next   = slot_inc(head_reg);
                                count_next  = count_reg - 1'b1;
                                state_next  = ST_READ_WAIT;
                            end
                        end
                        OP_READ:
                        begin
                            if (idx_ok)
                            begin
                                res_load    = 1'b0;
                                mem_rd_en   = 1'b1;
                                mem_rd_addr = slot_add(head_reg, idx_addr);
                                state_next  = ST_READ_WAIT;
                            end
                        end
                        OP_REMOVE:
                        begin
                            if (idx_ok)
                            begin
                                count_next     = count_reg - 1'b1;
                                res.status     = 1'b0;
                                res.item_count = COUNT_OUT_BITS'(count_next);
                                if (cmd.item_index == '0)
                                begin
                                    head_next = slot_inc(head_reg);
                                end
                                else if ((idx_count + COUNT_BITS'(1)) != count_reg)
                                begin
                                    mem_rd_en   = 1'b1;
                                    mem_rd_addr = slot_add(head_reg, idx_addr + 1'b1);
                                    rd_ptr_next = mem_rd_addr;
                                    wr_ptr_next = slot_add(head_reg, idx_addr);
                                    left_next   = count_reg - COUNT_BITS'(1) - idx_count;
                                    state_next  = ST_SHIFT;
                                end
                            end
                        end
                        OP_CLEAR:
                        begin
                            count_next     = '0;
                            res.status     = 1'b0;
                            res.item_count = '0;
                        end
                        default:
                        begin
                            res.status = 1'b1;
                        end
                    endcase
                end
            end
            ST_READ_WAIT:
            begin
                res_load      = 1'b1;
                res.status    = 1'b0;
                res.read_data = DATA_BITS'(mem_rd_data);
                state_next    = ST_IDLE;
            end
            ST_SHIFT:
            begin
                mem_wr_en   = 1'b1;
                mem_wr_addr = wr_ptr_reg;
                mem_wr_data = mem_rd_data;
                wr_ptr_next = slot_inc(wr_ptr_reg);
                left_next   = left_reg - 1'b1;
                if (left_reg == COUNT_BITS'(1))
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    mem_rd_en   = 1'b1;
                    mem_rd_addr = shift_rd;
                    rd_ptr_next = shift_rd;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            head_reg  <= '0;
            count_reg <= '0;
            left_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            head_reg  <= head_next;
            count_reg <= count_next;
            left_reg  <= left_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_ptr_reg <= rd_ptr_next;
        wr_ptr_reg <= wr_ptr_next;
    end

endmodule

### sv/fqir_checker.sv
module fqir_checker import fqir_pkg::*; (
    input logic                      clk,
    input logic                      rst_n,
    input logic                      cmd_valid,
    input logic                      cmd_ready,
    input logic [OP_BITS-1:0]        cmd_operation,
    input logic                      rsp_valid,
    input logic                      rsp_ready,
    input logic                      rsp_status,
    input logic [DATA_BITS-1:0]      rsp_read_data,
    input logic [COUNT_OUT_BITS-1:0] rsp_item_count
);

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
            && $stable(rsp_read_data) && $stable(rsp_item_count))
        else $error("response changed while stalled");

    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && cmd_ready |-> !rsp_valid || rsp_ready)
        else $error("command accepted while response slot is blocked");

    a_clear: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && cmd_ready && cmd_operation == OP_CLEAR
            |=> rsp_valid && !rsp_status && rsp_item_count == '0)
        else $error("clear did not report an empty queue");

    a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_status |-> rsp_read_data == '0)
        else $error("error response carries data");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> rsp_item_count <= COUNT_OUT_BITS'(DEPTH))
        else $error("item count beyond depth");

endmodule

bind fifo_queue_indexed_remove fqir_checker u_fqir_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd_valid      (cmd.valid),
    .cmd_ready      (cmd.ready),
    .cmd_operation  (cmd.operation),
    .rsp_valid      (rsp.valid),
    .rsp_ready      (rsp.ready),
    .rsp_status     (rsp.status),
    .rsp_read_data  (rsp.read_data),
    .rsp_item_count (rsp.item_count)
);

### tb/tb.sv
`timescale 1ns / 100ps

module tb;
    import fqir_pkg::*;

    localparam logic [OP_BITS-1:0] OP_UNDEF_LO = 3'd5;
    localparam logic [OP_BITS-1:0] OP_UNDEF_MID = 3'd6;
    localparam logic [OP_BITS-1:0] OP_UNDEF_HI = 3'd7;
    localparam int RANDOM_ITEMS = 2000;
    localparam int STALL_LIMIT = 2000;
    localparam int DRAIN_CYCLES = 20;
    localparam int REPORT_MAX = 10;

    typedef struct packed {
        logic [OP_BITS-1:0]        op;
        logic [INDEX_BITS-1:0]     idx;
        logic [DATA_BITS-1:0]      data;
        logic [4:0]                reps;
        logic                      typed;
        logic                      want_status;
        logic [DATA_BITS-1:0]      want_data;
        logic [COUNT_OUT_BITS-1:0] want_count;
    } dir_row_t;

    localparam int DIR_ROWS = 26;

    dir_row_t dir_tab [0:DIR_ROWS-1] = '{
        '{OP_TAKE,      4'd0,  32'h0000_0000, 5'd1,  1'b1, 1'b1, 32'h0, 5'd0},
        '{OP_READ,      4'd0,  32'h0000_0000, 5'd1,  1'b1, 1'b1, 32'h0, 5'd0},
        '{OP_REMOVE,    4'd15, 32'h0000_0000, 5'd1,  1'b1, 1'b1, 32'h0, 5'd0},
        '{OP_APPEND,    4'd0,  32'hFFFF_FFFF, 5'd1,  1'b1, 1'b0, 32'h0, 5'd1},
        '{OP_APPEND,    4'd15, 32'h0000_0000, 5'd1,  1'b1, 1'b0, 32'h0, 5'd2},
        '{OP_READ,      4'd1,  32'h0000_0000, 5'd1,  1'b0, 1'b0, 32'h0, 5'd0},
        '{OP_READ,      4'd2,  32'h0000_0000, 5'd1,  1'b1, 1'b1, 32'h0, 5'd2},
        '{OP_UNDEF_LO,  4'd0,  32'h0000_0000, 5'd1,  1'b1, 1'b1, 32'h0, 5'd2},
        '{OP_UNDEF_MID, 4'd15, 32'hFFFF_FFFF, 5'd1,  1'b1, 1'b1, 32'h0, 5'd2},
        '{OP_UNDEF_HI,  4'd1,  32'h0000_0000, 5'd1,  1'b1, 1'b1, 32'h0, 5'd2},
        '{OP_TAKE,      4'd0,  32'h0000_0000, 5'd1,  1'b0, 1'b0, 32'h0, 5'd0},
        '{OP_CLEAR,     4'd0,  32'h0000_0000, 5'd1,  1'b1, 1'b0, 32'h0, 5'd0},
        '{OP_CLEAR,     4'd15, 32'hFFFF_FFFF, 5'd1,  1'b1, 1'b0, 32'h0, 5'd0},
        '{OP_APPEND,    4'd0,  32'h8000_0001, 5'd16, 1'b0, 1'b0, 32'h0, 5'd0},
        '{OP_APPEND,    4'd0,  32'h1234_5678, 5'd1,  1'b1, 1'b1, 32'h0, 5'd16},
        '{OP_READ,      4'd15, 32'h0000_0000, 5'd1,  1'b0, 1'b0, 32'h0, 5'd0},
        '{OP_READ,      4'd0,  32'h0000_0000, 5'd1,  1'b0, 1'b0, 32'h0, 5'd0},
        '{OP_REMOVE,    4'd15, 32'h0000_0000, 5'd1,  1'b0, 1'b0, 32'h0, 5'd0},
        '{OP_REMOVE,    4'd7,  32'h0000_0000, 5'd1,  1'b0, 1'b0, 32'h0, 5'd0},
        '{OP_REMOVE,    4'd0,  32'h0000_0000, 5'd1,  1'b0, 1'b0, 32'h0, 5'd0},
        '{OP_READ,      4'd13, 32'h0000_0000, 5'd1,  1'b1, 1'b1, 32'h0, 5'd13},
        '{OP_TAKE,      4'd0,  32'h0000_0000, 5'd1,  1'b0, 1'b0, 32'h0, 5'd0},
        '{OP_REMOVE,    4'd15, 32'h0000_0000, 5'd1,  1'b1, 1'b1, 32'h0, 5'd12},
        '{OP_CLEAR,     4'd0,  32'h0000_0000, 5'd1,  1'b1, 1'b0, 32'h0, 5'd0},
        '{OP_APPEND,    4'd0,  32'h5555_5554, 5'd2,  1'b0, 1'b0, 32'h0, 5'd0},
        '{OP_READ,      4'd1,  32'h0000_0000, 5'd1,  1'b0, 1'b0, 32'h0, 5'd0}
    };

    logic clk;
    logic rst_n;

    fqir_in_if  cmd_if ();
    fqir_out_if rsp_if ();

    fifo_queue_indexed_remove uut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_if),
        .rsp   (rsp_if)
    );

    item_t   model_slots [DEPTH];
    int      model_count;
    result_t pending_q [$];
    int      error_count;
    int      idle_cycles;
    int      cycle_count;

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    function automatic result_t queue_predict(logic [OP_BITS-1:0] op,
                                              logic [INDEX_BITS-1:0] idx,
                                              logic [DATA_BITS-1:0] data);
        result_t res;
        int      pos;
        res.status    = 1'b1;
        res.read_data = '0;
        case (op)
            OP_APPEND:
            begin
                if (model_count < DEPTH)
                begin
                    model_slots[model_count] = item_t'(data);
                    model_count++;
                    res.status = 1'b0;
                end
            end
            OP_TAKE, OP_REMOVE:
            begin
                pos = (op == OP_TAKE) ? 0 : int'(idx);
                if (pos < model_count)
                begin
                    if (op == OP_TAKE)
                    begin
                        res.read_data = DATA_BITS'(model_slots[0]);
                    end
                    for (int i = pos; i + 1 < model_count; i++)
                    begin
                        model_slots[i] = model_slots[i + 1];
                    end
                    model_count--;
                    res.status = 1'b0;
                end
            end
            OP_READ:
            begin
                if (int'(idx) < model_count)
                begin
                    res.read_data = DATA_BITS'(model_slots[idx]);
                    res.status    = 1'b0;
                end
            end
            OP_CLEAR:
            begin
                model_count = 0;
                res.status  = 1'b0;
            end
            default:
            begin
                res.status = 1'b1;
            end
        endcase
        res.item_count = COUNT_OUT_BITS'(model_count);
        return res;
    endfunction

    function automatic int next_gap();
        int r;
        if ((cycle_count % 600) < 150)
        begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 60)
        begin
            return 0;
        end
        if (r < 92)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(4, 20);
    endfunction

    task automatic send_cmd(logic [OP_BITS-1:0] op, logic [INDEX_BITS-1:0] idx,
                            logic [DATA_BITS-1:0] data, logic typed, result_t want);
        result_t pred;
        int      gap;
        cmd_if.valid      <= 1'b1;
        cmd_if.operation  <= op;
        cmd_if.item_index <= idx;
        cmd_if.write_data <= data;
        @(posedge clk);
        while (!cmd_if.ready)
        begin
            @(posedge clk);
        end
        pred = queue_predict(op, idx, data);
        pending_q.push_back(typed ? want : pred);
        gap = next_gap();
        if (gap > 0)
        begin
            cmd_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic wait_drained();
        cmd_if.valid <= 1'b0;
        do
        begin
            @(posedge clk);
        end
        while (pending_q.size() != 0);
    endtask

    // result checker
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && rsp_if.valid && rsp_if.ready)
        begin
            if (pending_q.size() == 0)
            begin
                error_count++;
                if (error_count <= REPORT_MAX)
                begin
                    $display("unexpected transaction: status %0b data %h count %0d",
                             rsp_if.status, rsp_if.read_data, rsp_if.item_count);
                end
            end
            else
            begin
                want = pending_q.pop_front();
                if (rsp_if.status !== want.status || rsp_if.read_data !== want.read_data
                    || rsp_if.item_count !== want.item_count)
                begin
                    error_count++;
                    if (error_count <= REPORT_MAX)
                    begin
                        $display("mismatch: status %0b/%0b data %h/%h count %0d/%0d",
                                 want.status, rsp_if.status, want.read_data,
                                 rsp_if.read_data, want.item_count, rsp_if.item_count);
                    end
                end
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (!rst_n || (cmd_if.valid && cmd_if.ready) || (rsp_if.valid && rsp_if.ready))
        begin
            idle_cycles = 0;
        end
        else
        begin
            idle_cycles++;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    // response backpressure
    initial
    begin
        int stall_left;
        stall_left = 0;
        rsp_if.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (stall_left > 0)
            begin
                rsp_if.ready <= 1'b0;
                stall_left--;
            end
            else
            begin
                rsp_if.ready <= 1'b1;
                stall_left = next_gap();
            end
        end
    end

    initial
    begin
        logic [OP_BITS-1:0]    op;
        logic [INDEX_BITS-1:0] idx;
        logic [DATA_BITS-1:0]  data;
        int                    r;
        int                    append_weight;
        dir_row_t              row;
        error_count = 0;
        idle_cycles = 0;
        cycle_count = 0;
        model_count = 0;
        rst_n = 1'b0;
        cmd_if.valid      <= 1'b0;
        cmd_if.operation  <= OP_APPEND;
        cmd_if.item_index <= '0;
        cmd_if.write_data <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < DIR_ROWS; i++)
        begin
            row = dir_tab[i];
            for (int k = 0; k < int'(row.reps); k++)
            begin
                send_cmd(row.op, row.idx, row.data + DATA_BITS'(k), row.typed,
                         {row.want_status, row.want_data, row.want_count});
            end
        end
        wait_drained();

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n == RANDOM_ITEMS / 2)
            begin
                wait_drained();
            end
            append_weight = ((n / 150) % 2 == 0) ? 50 : 25;
            r = $urandom_range(0, 99);
            if (r < append_weight)
            begin
                op = OP_APPEND;
            end
            else if (r < 97)
            begin
                r = $urandom_range(0, 2);
                op = (r == 0) ? OP_TAKE : ((r == 1) ? OP_READ : OP_REMOVE);
            end
            else if (r == 97)
            begin
                op = OP_CLEAR;
            end
            else
            begin
                op = OP_BITS'($urandom_range(OP_UNDEF_LO, OP_UNDEF_HI));
            end
            if (model_count > 0 && $urandom_range(0, 9) < 8)
            begin
                idx = INDEX_BITS'($urandom_range(0, model_count - 1));
            end
            else
            begin
                idx = INDEX_BITS'($urandom_range(0, 15));
            end
            r = $urandom_range(0, 15);
            if (r == 0)
            begin
                data = '0;
            end
            else if (r == 1)
            begin
                data = '1;
            end
            else
            begin
                data = $urandom;
            end
            send_cmd(op, idx, data, 1'b0, '0);
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0)
        begin
            $display("DONE: 0 errors");
        end
        else
        begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
